// ===== hw/rtl/cffp_pkg.sv =====
package cffp_pkg;

  localparam logic [7:0] HEADER_RST     = 8'hFD;
  localparam logic [7:0] SPEED_CODE_RST = 8'h02;
  localparam logic [7:0] POWER_CODE_RST = 8'h04;

  localparam int CAP_DEPTH     = 9;
  localparam int CAP_IDX_W     = $clog2(CAP_DEPTH);
  localparam logic [7:0] SPEED_MIN_LEN = 8'd10;
  localparam logic [7:0] POWER_MIN_LEN = 8'd5;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_CODE = 2'd2;

  localparam logic KIND_SPEED = 1'b0;
  localparam logic KIND_POWER = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_CODE,
    PH_SDATA,
    PH_SCHECK,
    PH_PDATA,
    PH_PCHECK
  } phase_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] speed_code;
    logic [7:0] power_code;
  } cfg_t;

  // Packed lowest-first: frame_kind in bit 0, check_ok bit 1, then tdata fields.
  typedef struct packed {
    logic [15:0] power_use_time;
    logic [7:0]  power_capacity;
    logic [7:0]  power_voltage;
    logic [15:0] steer_angle;
    logic [7:0]  steer_direction;
    logic [15:0] y_speed;
    logic [7:0]  y_direction;
    logic [15:0] x_speed;
    logic [7:0]  x_direction;
    logic        check_ok;
    logic        frame_kind;
  } result_t;

  localparam int RES_W  = $bits(result_t);
  localparam int USER_W = 2;
  localparam int DATA_W = RES_W - USER_W;

endpackage

// ===== hw/rtl/cffp_parser.sv =====
module cffp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic [7:0]        rx_byte,
  input  cffp_pkg::cfg_t    cfg,
  output logic              res_valid,
  output cffp_pkg::result_t res
);
  import cffp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] byte_position, byte_position_next;
  logic [7:0] running_parity, running_parity_next;
  logic [7:0] captured [CAP_DEPTH];
  logic       cap_we;

  logic [7:0]  held_x_direction, held_y_direction, held_steer_direction;
  logic [15:0] held_x_speed, held_y_speed, held_steer_angle;
  logic [7:0]  held_voltage, held_capacity;
  logic [15:0] held_use_time;

  logic [7:0] data_count;
  logic [7:0] pos_inc;
  logic       is_power, check_ok, upd_speed, upd_power;

  assign data_count = (frame_length == 8'd0) ? 8'd0 : frame_length - 8'd1;
  assign pos_inc    = byte_position + 8'd1;
  assign is_power   = (phase == PH_PCHECK);
  assign check_ok   = (rx_byte == running_parity) &&
                      (frame_length >= (is_power ? POWER_MIN_LEN : SPEED_MIN_LEN));
  assign res_valid  = in_accept && (phase == PH_SCHECK || phase == PH_PCHECK);
  assign upd_speed  = res_valid && check_ok && !is_power;
  assign upd_power  = res_valid && check_ok && is_power;
  assign cap_we     = in_accept && (phase == PH_SDATA || phase == PH_PDATA) &&
                      (byte_position < 8'(CAP_DEPTH));

  always_comb begin
    phase_next          = phase;
    frame_length_next   = frame_length;
    byte_position_next  = byte_position;
    running_parity_next = running_parity;
    if (in_accept) begin
      unique case (phase)
        PH_LEN: begin
          frame_length_next = rx_byte;
          phase_next        = PH_CODE;
        end
        PH_CODE: begin
          running_parity_next = rx_byte;
          byte_position_next  = 8'd0;
          if (rx_byte == cfg.speed_code) begin
            phase_next = (data_count == 8'd0) ? PH_SCHECK : PH_SDATA;
          end else if (rx_byte == cfg.power_code) begin
            phase_next = (data_count == 8'd0) ? PH_PCHECK : PH_PDATA;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_SDATA, PH_PDATA: begin
          running_parity_next = running_parity ^ rx_byte;
          byte_position_next  = pos_inc;
          if (pos_inc >= data_count) begin
            phase_next = (phase == PH_SDATA) ? PH_SCHECK : PH_PCHECK;
          end
        end
        PH_SCHECK, PH_PCHECK: phase_next = PH_HUNT;
        default: phase_next = (rx_byte == cfg.header_byte) ? PH_LEN : PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      frame_length   <= 8'd0;
      byte_position  <= 8'd0;
      running_parity <= 8'd0;
    end else begin
      phase          <= phase_next;
      frame_length   <= frame_length_next;
      byte_position  <= byte_position_next;
      running_parity <= running_parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAP_DEPTH; i++) captured[i] <= 8'd0;
    end else if (cap_we) begin
      captured[byte_position[CAP_IDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_x_direction     <= 8'd0;
      held_x_speed         <= 16'd0;
      held_y_direction     <= 8'd0;
      held_y_speed         <= 16'd0;
      held_steer_direction <= 8'd0;
      held_steer_angle     <= 16'd0;
      held_voltage         <= 8'd0;
      held_capacity        <= 8'd0;
      held_use_time        <= 16'd0;
    end else begin
      if (upd_speed) begin
        held_x_direction     <= res.x_direction;
        held_x_speed         <= res.x_speed;
        held_y_direction     <= res.y_direction;
        held_y_speed         <= res.y_speed;
        held_steer_direction <= res.steer_direction;
        held_steer_angle     <= res.steer_angle;
      end
      if (upd_power) begin
        held_voltage  <= res.power_voltage;
        held_capacity <= res.power_capacity;
        held_use_time <= res.power_use_time;
      end
    end
  end

  // Result carries the held values as they stand after this frame.
  always_comb begin
    res.frame_kind      = is_power ? KIND_POWER : KIND_SPEED;
    res.check_ok        = check_ok;
    res.x_direction     = upd_speed ? captured[0] : held_x_direction;
    res.x_speed         = upd_speed ? {captured[1], captured[2]} : held_x_speed;
    res.y_direction     = upd_speed ? captured[3] : held_y_direction;
    res.y_speed         = upd_speed ? {captured[4], captured[5]} : held_y_speed;
    res.steer_direction = upd_speed ? captured[6] : held_steer_direction;
    res.steer_angle     = upd_speed ? {captured[7], captured[8]} : held_steer_angle;
    res.power_voltage   = upd_power ? captured[0] : held_voltage;
    res.power_capacity  = upd_power ? captured[1] : held_capacity;
    res.power_use_time  = upd_power ? {captured[2], captured[3]} : held_use_time;
  end

  a_check_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> phase == PH_HUNT)
    else $error("parser did not resume hunting after check byte");

  a_held_stable_when_idle: assert property (@(posedge clk) disable iff (rst)
    !res_valid |=> $stable(held_x_speed) && $stable(held_use_time))
    else $error("held value changed without a completed frame");

  a_no_update_on_fail: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !check_ok) |=> $stable(held_voltage) && $stable(held_steer_angle))
    else $error("held value changed on failed check");

endmodule

// ===== hw/rtl/cffp_out_skid.sv =====
module cffp_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  cffp_pkg::result_t in_res,
  output logic              in_ready,
  output logic              out_valid,
  output cffp_pkg::result_t out_res,
  input  logic              out_ready
);
  import cffp_pkg::*;

  logic    skid_valid;
  result_t skid_res;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_res    <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid || out_ready) begin
        out_res   <= in_res;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= in_res;
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a request while output is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> out_valid && !skid_valid)
    else $error("skid request not moved to output");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_valid && !out_ready) |=> skid_valid)
    else $error("request lost while output stalled");

endmodule

// ===== hw/rtl/chassis_feedback_frame_parser_top.sv =====
// Chassis feedback frame parser. One received byte enters per request on the
// s_ side; the parser hunts for the header byte, then takes a length byte L, a
// code byte, L-1 data bytes and an XOR check byte (XOR of code and data). Each
// completed frame with the speed or power code gives one request on the m_
// side: tuser holds the frame kind and check result, tdata the held values as
// they stand after that frame (updated only on a good check of a long enough
// frame). A byte is taken every cycle while s_tready is high: the parser
// updates in the cycle of the byte; the result is registered in the output
// register, or in the skid when the output stalls. A two-deep output register
// (output plus skid) decouples the sides; s_tready drops only while both hold
// undelivered results. Config writes are always accepted and should be made
// with the parser idle; unknown indexes are ignored.
module chassis_feedback_frame_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cffp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  // byte stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // rx_byte
  // frame results out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // x_direction, x_speed, y_direction, y_speed, steer_direction, steer_angle,
  // power_voltage, power_capacity, power_use_time
  output logic [cffp_pkg::DATA_W-1:0]     m_tdata,
  output logic [cffp_pkg::USER_W-1:0]     m_tuser    // frame_kind, check_ok
);
  import cffp_pkg::*;

  cfg_t    cfg;
  logic    in_accept;
  logic    res_valid;
  result_t res, out_res;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_byte <= HEADER_RST;
      cfg.speed_code  <= SPEED_CODE_RST;
      cfg.power_code  <= POWER_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER:     cfg.header_byte <= cfg_data;
        REG_SPEED_CODE: cfg.speed_code  <= cfg_data;
        REG_POWER_CODE: cfg.power_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_accept = s_tvalid && s_tready;

  cffp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .rx_byte   (s_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  cffp_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tuser = out_res[USER_W-1:0];
  assign m_tdata = out_res[RES_W-1:USER_W];

endmodule
